### design/slc_pkg.sv
// slc_pkg: shared types and constants of the single-linkage clustering unit
// no dependencies
package slc_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int TW = 7;   // target_groups width
    localparam int CRD_W = 16;
    localparam int IDX_W = 6;
    localparam int DSQ_W = 33;
    localparam int DW = 34;
    localparam logic [DW-1:0] DIST_MAX = 34'h3_FFFF_FFFF;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RUN  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BUILD,
        S_BDRAIN,
        S_SCAN,
        S_SDRAIN,
        S_MERGE,
        S_UPD,
        S_UDRAIN,
        S_EMPTY
    } t_state;

endpackage

### design/slc_if.sv
// slc_if: valid/ready channels of the clustering unit (config, points in, records out)
// depends on slc_pkg
interface slc_cfg_if;
    logic                    valid;
    logic                    ready;
    logic [slc_pkg::TW-1:0]  target_groups;
    modport source (output valid, output target_groups, input ready);
    modport sink   (input valid, input target_groups, output ready);
endinterface

interface slc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic signed [slc_pkg::CRD_W-1:0] x_coord;
    logic signed [slc_pkg::CRD_W-1:0] y_coord;
    modport source (output valid, output func, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input func, input x_coord, input y_coord, output ready);
endinterface

interface slc_out_if;
    logic                       valid;
    logic                       ready;
    logic [slc_pkg::IDX_W-1:0]  keeper_index;
    logic [slc_pkg::IDX_W-1:0]  merged_index;
    logic [slc_pkg::DSQ_W-1:0]  merge_distance_sq;
    logic                       is_merge;
    logic                       last;
    modport source (output valid, output keeper_index, output merged_index,
                    output merge_distance_sq, output is_merge, output last, input ready);
    modport sink   (input valid, input keeper_index, input merged_index,
                    input merge_distance_sq, input is_merge, input last, output ready);
endinterface

### design/single_linkage_clustering_unit.sv
// single_linkage_clustering_unit: point store, distance memory and merge sequencer
// a load word stores one point. a run word first builds the distance memory over all pairs,
// then per merge scans all pairs for the minimum and updates the kept point's row
// with the smaller of the two old distances to every other point.
// synchronous active-low reset clears control, point count and target (to 1);
// memories are not cleared. depends on slc_pkg and slc_if
module single_linkage_clustering_unit #(
    parameter int MAX_POINTS = slc_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slc_cfg_if.sink     i_cfg,
    slc_in_if.sink      i_in,
    slc_out_if.source   o_out
);
    import slc_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int GW = (CW > TW) ? CW : TW;
    localparam int AW = 2 * IW;

    function automatic logic [AW-1:0] f_pair(input logic [IW-1:0] a, input logic [IW-1:0] b);
        f_pair = (a < b) ? {a, b} : {b, a};
    endfunction

    t_state r_state, n_state;

    logic [TW-1:0]        r_target;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_groups;
    logic [MAX_POINTS-1:0] r_alive;
    logic [IW-1:0]        r_i, r_j, r_k, r_u, r_v;
    logic [DW-1:0]        r_best;
    logic                 r_found, r_cont;

    // point store
    logic signed [CRD_W-1:0] m_px [MAX_POINTS];
    logic signed [CRD_W-1:0] m_py [MAX_POINTS];
    logic signed [CRD_W-1:0] r_xa, r_xb, r_ya, r_yb;

    // build pipeline
    logic                  r_b1, r_b2, r_b3;
    logic [IW-1:0]         r_b1_i, r_b1_j, r_b2_i, r_b2_j, r_b3_i, r_b3_j;
    logic signed [CRD_W:0] r_dx, r_dy;
    logic [31:0]           r_sqx, r_sqy;

    // distance memory, upper triangle addressed by {low, high}
    logic [DW-1:0] m_dist [1 << AW];
    logic [DW-1:0] r_qa, r_qb;
    logic [AW-1:0] w_ra, w_rb, w_wa;
    logic [DW-1:0] w_wd;
    logic          w_we;

    logic          r_s1;
    logic [IW-1:0] r_s1_i, r_s1_j;
    logic          r_u1;
    logic [IW-1:0] r_u1_k;

    logic          r_ov;
    logic [IDX_W-1:0] r_keep, r_gone;
    logic [DSQ_W-1:0] r_dsq;
    logic          r_ism, r_last;

    logic          w_ready, w_acc, w_run, w_do;
    logic [IW-1:0] w_n1;
    logic          w_pair_last;
    logic [CW-1:0] w_gnew;
    logic [DW-1:0] w_min;

    assign w_n1        = IW'(r_count - CW'(1));
    assign w_pair_last = (r_j == w_n1) && (r_i == w_n1 - IW'(1));
    assign w_acc       = i_in.valid && w_ready;
    assign w_run       = i_in.func == FUNC_RUN;
    assign w_do        = (r_count >= CW'(2)) && (GW'(r_count) > GW'(r_target));
    assign w_gnew      = r_groups - CW'(1);
    assign w_min       = (r_qa < r_qb) ? r_qa : r_qb;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_ready;

    assign o_out.valid             = r_ov;
    assign o_out.keeper_index      = r_keep;
    assign o_out.merged_index      = r_gone;
    assign o_out.merge_distance_sq = r_dsq;
    assign o_out.is_merge          = r_ism;
    assign o_out.last              = r_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && w_run) n_state = w_do ? S_BUILD : S_EMPTY;
            end
            S_BUILD:  if (w_pair_last) n_state = S_BDRAIN;
            S_BDRAIN: if (!r_b1 && !r_b2 && !r_b3) n_state = S_SCAN;
            S_SCAN:   if (w_pair_last) n_state = S_SDRAIN;
            S_SDRAIN: n_state = S_MERGE;
            S_MERGE:  if (!r_ov) n_state = S_UPD;
            S_UPD:    if (r_k == w_n1) n_state = S_UDRAIN;
            S_UDRAIN: n_state = r_cont ? S_SCAN : S_IDLE;
            S_EMPTY:  if (!r_ov) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake and memory port selection
    always_comb begin
        w_ready = 1'b0;
        w_ra    = f_pair(r_i, r_j);
        w_rb    = f_pair(r_v, r_k);
        w_we    = 1'b0;
        w_wa    = f_pair(r_b3_i, r_b3_j);
        w_wd    = {2'b00, r_sqx} + {2'b00, r_sqy};
        unique case (r_state)
            S_IDLE: w_ready = 1'b1;
            S_BUILD, S_BDRAIN: w_we = r_b3;
            S_UPD, S_UDRAIN: begin
                w_ra = f_pair(r_u, r_k);
                w_we = r_u1;
                w_wa = f_pair(r_u, r_u1_k);
                w_wd = w_min;
            end
            default: w_ready = 1'b0;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_acc && !w_run && (r_count < CW'(MAX_POINTS))) begin
            m_px[IW'(r_count)] <= i_in.x_coord;
            m_py[IW'(r_count)] <= i_in.y_coord;
        end
        r_xa <= m_px[r_i];
        r_xb <= m_px[r_j];
        r_ya <= m_py[r_i];
        r_yb <= m_py[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) m_dist[w_wa] <= w_wd;
        r_qa <= m_dist[w_ra];
        r_qb <= m_dist[w_rb];
    end

    // build datapath payload
    always_ff @(posedge i_clk) begin
        r_b1_i <= r_i;
        r_b1_j <= r_j;
        r_b2_i <= r_b1_i;
        r_b2_j <= r_b1_j;
        r_b3_i <= r_b2_i;
        r_b3_j <= r_b2_j;
        r_dx   <= (CRD_W+1)'(r_xa) - (CRD_W+1)'(r_xb);
        r_dy   <= (CRD_W+1)'(r_ya) - (CRD_W+1)'(r_yb);
        r_sqx  <= 32'(r_dx * r_dx);
        r_sqy  <= 32'(r_dy * r_dy);
        r_s1_i <= r_i;
        r_s1_j <= r_j;
        r_u1_k <= r_k;
    end

    // control and sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_target <= TW'(1);
            r_count  <= '0;
            r_groups <= '0;
            r_alive  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_u      <= '0;
            r_v      <= '0;
            r_best   <= DIST_MAX;
            r_found  <= 1'b0;
            r_cont   <= 1'b0;
            r_b1     <= 1'b0;
            r_b2     <= 1'b0;
            r_b3     <= 1'b0;
            r_s1     <= 1'b0;
            r_u1     <= 1'b0;
            r_ov     <= 1'b0;
            r_keep   <= '0;
            r_gone   <= '0;
            r_dsq    <= '0;
            r_ism    <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) r_target <= i_cfg.target_groups;
            if (r_ov && o_out.ready) r_ov <= 1'b0;

            r_b1 <= (r_state == S_BUILD);
            r_b2 <= r_b1;
            r_b3 <= r_b2;
            r_s1 <= (r_state == S_SCAN);
            r_u1 <= (r_state == S_UPD) && r_alive[r_k] && (r_k != r_u);

            // scan compare, strict less keeps the first pair on a tie
            if (r_s1 && r_alive[r_s1_i] && r_alive[r_s1_j] && (r_qa < r_best)) begin
                r_best  <= r_qa;
                r_u     <= r_s1_i;
                r_v     <= r_s1_j;
                r_found <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && !w_run && (r_count < CW'(MAX_POINTS)))
                        r_count <= r_count + CW'(1);
                    if (w_acc && w_run) begin
                        r_i      <= '0;
                        r_j      <= IW'(1);
                        r_groups <= r_count;
                        for (int k = 0; k < MAX_POINTS; k++)
                            r_alive[k] <= (CW'(k) < r_count);
                    end
                end
                S_BUILD, S_SCAN: begin
                    if (r_j == w_n1) begin
                        r_i <= r_i + IW'(1);
                        r_j <= r_i + IW'(1) + IW'(1);
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
                S_BDRAIN: begin
                    r_i     <= '0;
                    r_j     <= IW'(1);
                    r_best  <= DIST_MAX;
                    r_found <= 1'b0;
                end
                S_MERGE: begin
                    if (!r_ov) begin
                        r_alive[r_v] <= 1'b0;
                        r_ov     <= 1'b1;
                        r_keep   <= IDX_W'(r_u);
                        r_gone   <= IDX_W'(r_v);
                        r_dsq    <= DSQ_W'(r_best);
                        r_ism    <= 1'b1;
                        r_cont   <= (GW'(w_gnew) > GW'(r_target)) && (w_gnew >= CW'(2));
                        r_last   <= !((GW'(w_gnew) > GW'(r_target)) && (w_gnew >= CW'(2)));
                        r_groups <= w_gnew;
                        r_k      <= '0;
                    end
                end
                S_UPD: r_k <= r_k + IW'(1);
                S_UDRAIN: begin
                    r_i     <= '0;
                    r_j     <= IW'(1);
                    r_best  <= DIST_MAX;
                    r_found <= 1'b0;
                    if (!r_cont) r_count <= '0;
                end
                S_EMPTY: begin
                    if (!r_ov) begin
                        r_ov    <= 1'b1;
                        r_keep  <= '0;
                        r_gone  <= '0;
                        r_dsq   <= '0;
                        r_ism   <= 1'b0;
                        r_last  <= 1'b1;
                        r_count <= '0;
                    end
                end
                default: r_found <= r_found;
            endcase
        end
    end

endmodule
